// ===== hdl/uart_receiver_with_ring_buffer_assert.svh =====
// ----------------------------------------------------------------------------
// uart_receiver_with_ring_buffer_assert
// Assertion macros shared by the receiver modules.
// ----------------------------------------------------------------------------
`ifndef UART_RECEIVER_WITH_RING_BUFFER_ASSERT_SVH
`define UART_RECEIVER_WITH_RING_BUFFER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define URRB_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define URRB_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/urrb_pkg.sv =====
// ----------------------------------------------------------------------------
// urrb_pkg
// Shared types and constants of the uart receiver with receive ring buffer.
// ----------------------------------------------------------------------------
package urrb_pkg;

    // field widths
    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int TICK_W  = 16;
    localparam int FILL_W  = 6;
    localparam int CFG_IDX_W = 2;

    // host commands
    localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLR_OVF = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TICKS   = 2'd2;

    // configuration reset values
    localparam logic [TICK_W-1:0] CENTER_TICKS_RST = 16'd50;
    localparam logic [TICK_W-1:0] BIT_TICKS_RST    = 16'd114;
    localparam logic [TICK_W-1:0] STOP_TICKS_RST   = 16'd114;

    // decoupling queue between receiver and buffer
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // receiver phases
    typedef enum logic [3:0] {
        RX_IDLE   = 4'b0001,
        RX_CENTER = 4'b0010,
        RX_DATA   = 4'b0100,
        RX_STOP   = 4'b1000
    } rx_phase_t;

    // one classified item: host command plus a finished byte, if any
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              push;
        logic [BYTE_W-1:0] data;
    } queue_entry_t;

endpackage

// ===== hdl/urrb_rx_front.sv =====
// ----------------------------------------------------------------------------
// urrb_rx_front
// 8N1 receive state machine and timing registers; turns each sample tick
// into a queue entry carrying the host command and any completed byte.
// ----------------------------------------------------------------------------
module urrb_rx_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [urrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [urrb_pkg::TICK_W-1:0]    cfg_data,
    input  logic                           tick_accept,
    input  logic [urrb_pkg::CMD_W-1:0]     command,
    input  logic                           rx_level,
    output urrb_pkg::queue_entry_t         entry
);
    import urrb_pkg::*;

    logic [TICK_W-1:0] center_ticks_reg;
    logic [TICK_W-1:0] bit_ticks_reg;
    logic [TICK_W-1:0] stop_ticks_reg;

    rx_phase_t         phase_reg, phase_next;
    logic              armed_reg, armed_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [2:0]        bit_idx_reg, bit_idx_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;

    logic [TICK_W:0]   tick_inc;
    logic              push;

    // timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_ticks_reg <= CENTER_TICKS_RST;
            bit_ticks_reg    <= BIT_TICKS_RST;
            stop_ticks_reg   <= STOP_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_TICKS: center_ticks_reg <= cfg_data;
                CFG_BIT_TICKS:    bit_ticks_reg    <= cfg_data;
                CFG_STOP_TICKS:   stop_ticks_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign tick_inc = {1'b0, tick_reg} + {{TICK_W{1'b0}}, 1'b1};

    // frame sequencing
    always_comb
    begin
        phase_next   = phase_reg;
        armed_next   = armed_reg;
        tick_next    = tick_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        push         = 1'b0;
        case (phase_reg)
            RX_IDLE:
            begin
                if (rx_level)
                begin
                    armed_next = 1'b1;
                end
                else if (armed_reg)
                begin
                    armed_next   = 1'b0;
                    tick_next    = '0;
                    bit_idx_next = '0;
                    shift_next   = '0;
                    phase_next   = (center_ticks_reg == '0) ? RX_DATA : RX_CENTER;
                end
            end
            RX_CENTER:
            begin
                tick_next = tick_inc[TICK_W-1:0];
                if (tick_inc >= {1'b0, center_ticks_reg})
                begin
                    tick_next  = '0;
                    phase_next = RX_DATA;
                end
            end
            RX_DATA:
            begin
                tick_next = tick_inc[TICK_W-1:0];
                if (tick_inc >= {1'b0, bit_ticks_reg})
                begin
                    tick_next               = '0;
                    shift_next[bit_idx_reg] = rx_level;
                    bit_idx_next            = bit_idx_reg + 3'd1;
                    if (bit_idx_reg == 3'd7)
                    begin
                        phase_next = RX_STOP;
                    end
                end
            end
            RX_STOP:
            begin
                tick_next = tick_inc[TICK_W-1:0];
                if (tick_inc >= {1'b0, stop_ticks_reg})
                begin
                    tick_next  = '0;
                    push       = 1'b1;
                    armed_next = rx_level;
                    phase_next = RX_IDLE;
                end
            end
            default:
            begin
                phase_next = RX_IDLE;
            end
        endcase
    end

    // receiver state, advanced once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= RX_IDLE;
            armed_reg   <= 1'b1;
            tick_reg    <= '0;
            bit_idx_reg <= '0;
            shift_reg   <= '0;
        end
        else if (tick_accept)
        begin
            phase_reg   <= phase_next;
            armed_reg   <= armed_next;
            tick_reg    <= tick_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg   <= shift_next;
        end
    end

    // classified item toward the queue
    assign entry.cmd  = command;
    assign entry.push = push;
    assign entry.data = shift_reg;

endmodule

// ===== hdl/urrb_queue.sv =====
// ----------------------------------------------------------------------------
// urrb_queue
// Short queue between the receiver front and the buffer back end.
// ----------------------------------------------------------------------------
module urrb_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  urrb_pkg::queue_entry_t wr_entry,
    output logic                   full,
    input  logic                   rd_en,
    output logic                   rd_valid,
    output urrb_pkg::queue_entry_t rd_entry
);
    import urrb_pkg::*;

    `include "uart_receiver_with_ring_buffer_assert.svh"

    queue_entry_t      slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = slot_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    // pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `URRB_ASSERT_IMPL(a_q_no_overrun, clk, rst_n, full, !wr_en, "queue written while full")
    `URRB_ASSERT_IMPL(a_q_no_underrun, clk, rst_n, !rd_valid, !rd_en, "queue read while empty")
    `URRB_ASSERT_NEXT(a_q_count_up, clk, rst_n, wr_en && !rd_en, count_reg == $past(count_reg) + 1'b1, "queue count did not grow")

endmodule

// ===== hdl/urrb_fifo_back.sv =====
// ----------------------------------------------------------------------------
// urrb_fifo_back
// Receive ring buffer: stores bytes, serves pop, peek, flush and overflow
// clear, and holds the result register toward the host.
// ----------------------------------------------------------------------------
module urrb_fifo_back
#(
    parameter int FIFO_DEPTH = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  urrb_pkg::queue_entry_t        q_entry,
    output logic                          q_pop,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [urrb_pkg::BYTE_W-1:0]   read_data,
    output logic                          read_valid,
    output logic [urrb_pkg::FILL_W-1:0]   fill_count,
    output logic                          overflow
);
    import urrb_pkg::*;

    `include "uart_receiver_with_ring_buffer_assert.svh"

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = (PTR_W + 1 > FILL_W) ? PTR_W + 1 : FILL_W;

    logic [BYTE_W-1:0] mem [FIFO_DEPTH];

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic              ovf_reg, ovf_next;

    // result stage
    logic              res_valid_reg;
    logic              res_hit_reg;
    logic              res_byp_reg;
    logic [BYTE_W-1:0] res_byp_data_reg;
    logic [BYTE_W-1:0] res_mem_data_reg;
    logic [FILL_W-1:0] res_fill_reg;
    logic              res_ovf_reg;

    logic              fire;
    logic [PTR_W-1:0]  tail_inc;
    logic [PTR_W-1:0]  head_inc;
    logic              full;
    logic              do_write;
    logic [PTR_W-1:0]  tail_pushed;
    logic              ovf_seen;
    logic              is_read;
    logic              hit;
    logic              bypass;
    logic [CNT_W-1:0]  fill_wide;

    assign fire  = q_valid && (!res_valid_reg || !result_stall);
    assign q_pop = fire;

    assign tail_inc = (tail_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_inc = (head_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // receive side goes first: append the byte or flag the overflow
    assign full        = (tail_inc == head_reg);
    assign do_write    = q_entry.push && !full;
    assign tail_pushed = do_write ? tail_inc : tail_reg;
    assign ovf_seen    = ovf_reg || (q_entry.push && full);

    // host side: a read of a byte written in this same item takes the bypass
    assign is_read = (q_entry.cmd inside {CMD_POP, CMD_PEEK});
    assign hit     = is_read && (head_reg != tail_pushed);
    assign bypass  = do_write && (head_reg == tail_reg);

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_pushed;
        ovf_next  = ovf_seen;
        case (q_entry.cmd)
            CMD_POP:
            begin
                if (hit)
                begin
                    head_next = head_inc;
                end
            end
            CMD_FLUSH:
            begin
                head_next = '0;
                tail_next = '0;
            end
            CMD_CLR_OVF:
            begin
                ovf_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // occupancy after this item, reported modulo the field width
    always_comb
    begin
        if (tail_next >= head_next)
        begin
            fill_wide = CNT_W'(tail_next) - CNT_W'(head_next);
        end
        else
        begin
            fill_wide = CNT_W'(tail_next) + CNT_W'(FIFO_DEPTH) - CNT_W'(head_next);
        end
    end

    // byte storage with registered read at the head
    always_ff @(posedge clk)
    begin
        if (fire && do_write)
        begin
            mem[tail_reg] <= q_entry.data;
        end
        if (fire)
        begin
            res_mem_data_reg <= mem[head_reg];
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_hit_reg      <= hit;
            res_byp_reg      <= bypass;
            res_byp_data_reg <= q_entry.data;
            res_fill_reg     <= fill_wide[FILL_W-1:0];
            res_ovf_reg      <= ovf_seen;
        end
    end

    // pointers, flag and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                ovf_reg  <= ovf_next;
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign read_valid   = res_hit_reg;
    assign read_data    = !res_hit_reg ? '0 :
                          (res_byp_reg ? res_byp_data_reg : res_mem_data_reg);
    assign fill_count   = res_fill_reg;
    assign overflow     = res_ovf_reg;

    `URRB_ASSERT_IMPL(a_ptr_range, clk, rst_n, 1'b1, (head_reg <= PTR_W'(FIFO_DEPTH - 1)) && (tail_reg <= PTR_W'(FIFO_DEPTH - 1)), "ring pointer out of range")
    `URRB_ASSERT_NEXT(a_flush_empty, clk, rst_n, fire && (q_entry.cmd == CMD_FLUSH), (head_reg == tail_reg) && (res_fill_reg == '0), "flush left bytes behind")
    `URRB_ASSERT_NEXT(a_ovf_on_full, clk, rst_n, fire && q_entry.push && full && (q_entry.cmd != CMD_FLUSH), res_ovf_reg && (tail_reg == $past(tail_reg)), "byte into full buffer not flagged")

endmodule

// ===== hdl/uart_receiver_with_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// uart_receiver_with_ring_buffer
// 8N1 receiver driven by one sample tick per transfer, with a host-side
// receive ring buffer (pop, peek, flush, read-and-clear overflow).
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   item     | item_valid/item_stall | command, rx_level
//   result   | result_valid/stall    | read_data, read_valid, fill_count,
//            |                       | overflow
//   cfg      | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One tick transfer is taken every cycle unless item_stall is high. The
// receiver works on the tick in the accept cycle, the buffer stage does the
// pointer update and the registered memory read at the head. A two-entry queue
// between the receiver and the buffer lets item transfers continue while the
// result register is stalled; item_stall rises only when that queue is full. No
// clearing pass after reset; cfg_ready is always high.
// ----------------------------------------------------------------------------
module uart_receiver_with_ring_buffer
#(
    parameter int FIFO_DEPTH = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // tick input
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [urrb_pkg::CMD_W-1:0]     command,
    input  logic                           rx_level,
    // result output
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [urrb_pkg::BYTE_W-1:0]    read_data,
    output logic                           read_valid,
    output logic [urrb_pkg::FILL_W-1:0]    fill_count,
    output logic                           overflow,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [urrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [urrb_pkg::TICK_W-1:0]    cfg_data
);
    import urrb_pkg::*;

    logic         tick_accept;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;
    queue_entry_t front_entry;
    queue_entry_t back_entry;

    assign cfg_ready   = 1'b1;
    assign item_stall  = q_full;
    assign tick_accept = item_valid && !q_full;

    // receiver front
    urrb_rx_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .tick_accept (tick_accept),
        .command     (command),
        .rx_level    (rx_level),
        .entry       (front_entry)
    );

    // decoupling queue
    urrb_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tick_accept),
        .wr_entry (front_entry),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_entry (back_entry)
    );

    // ring buffer back end
    urrb_fifo_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_entry      (back_entry),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .read_data    (read_data),
        .read_valid   (read_valid),
        .fill_count   (fill_count),
        .overflow     (overflow)
    );

endmodule

// ===== bench/urrb_read_checker.sv =====
// ----------------------------------------------------------------------------
// urrb_read_checker
// Watches the tick, result and configuration channels of the uart receiver
// with ring buffer. Keeps its own copy of the receiver, the ring buffer and
// the timing registers, predicts one read result per accepted tick and
// compares every result transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module urrb_read_checker
#(
    parameter int FIFO_DEPTH = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  logic                           item_stall,
    input  logic [urrb_pkg::CMD_W-1:0]     command,
    input  logic                           rx_level,
    input  logic                           result_valid,
    input  logic                           result_stall,
    input  logic [urrb_pkg::BYTE_W-1:0]    read_data,
    input  logic                           read_valid,
    input  logic [urrb_pkg::FILL_W-1:0]    fill_count,
    input  logic                           overflow,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [urrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [urrb_pkg::TICK_W-1:0]    cfg_data,
    output int                             error_count,
    output int                             pending,
    output int                             reads_checked,
    output int                             bytes_stored,
    output int                             bytes_dropped
);
    timeunit 1ns;
    timeprecision 1ps;

    import urrb_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic [FILL_W-1:0] fill;
        logic              ovf;
    } read_result_t;

    // timing registers as last written
    logic [TICK_W-1:0] center_cfg;
    logic [TICK_W-1:0] bit_cfg;
    logic [TICK_W-1:0] stop_cfg;

    // receiver state
    rx_phase_t         phase;
    logic              line_armed;
    int unsigned       tick_cnt;
    int                bit_pos;
    logic [BYTE_W-1:0] shift_reg;

    // ring buffer state, one slot kept empty
    logic [BYTE_W-1:0] ring [FIFO_DEPTH];
    int                head;
    int                tail;
    logic              ovf_flag;

    read_result_t      expected_reads [$];

    task automatic reset_model();
        center_cfg    = CENTER_TICKS_RST;
        bit_cfg       = BIT_TICKS_RST;
        stop_cfg      = STOP_TICKS_RST;
        phase         = RX_IDLE;
        line_armed    = 1'b1;
        tick_cnt      = 0;
        bit_pos       = 0;
        shift_reg     = '0;
        head          = 0;
        tail          = 0;
        ovf_flag      = 1'b0;
        error_count   = 0;
        pending       = 0;
        reads_checked = 0;
        bytes_stored  = 0;
        bytes_dropped = 0;
        expected_reads.delete();
    endtask

    // append a received byte, or flag overflow when full
    task automatic store_byte(input logic [BYTE_W-1:0] value);
        int nxt;
        nxt = (tail + 1) % FIFO_DEPTH;
        if (nxt != head)
        begin
            ring[tail] = value;
            tail = nxt;
            bytes_stored++;
        end
        else
        begin
            ovf_flag = 1'b1;
            bytes_dropped++;
        end
    endtask

    // one sample tick of the 8n1 receiver
    task automatic sample_line(input logic lvl);
        case (phase)
            RX_IDLE:
            begin
                if (lvl)
                    line_armed = 1'b1;
                else if (line_armed)
                begin
                    line_armed = 1'b0;
                    tick_cnt   = 0;
                    bit_pos    = 0;
                    shift_reg  = '0;
                    phase      = (center_cfg == 0) ? RX_DATA : RX_CENTER;
                end
            end
            RX_CENTER:
            begin
                tick_cnt++;
                if (tick_cnt >= center_cfg)
                begin
                    tick_cnt = 0;
                    phase    = RX_DATA;
                end
            end
            RX_DATA:
            begin
                tick_cnt++;
                if (tick_cnt >= bit_cfg)
                begin
                    tick_cnt = 0;
                    shift_reg[bit_pos] = lvl;
                    if (bit_pos == BYTE_W - 1)
                    begin
                        bit_pos = 0;
                        phase   = RX_STOP;
                    end
                    else
                        bit_pos++;
                end
            end
            default:
            begin
                tick_cnt++;
                if (tick_cnt >= stop_cfg)
                begin
                    tick_cnt = 0;
                    store_byte(shift_reg);
                    line_armed = lvl;
                    phase      = RX_IDLE;
                end
            end
        endcase
    endtask

    // receiver first, then the host command
    task automatic predict_read(input logic [CMD_W-1:0] cmd, input logic lvl,
                                output read_result_t res);
        sample_line(lvl);
        res     = '0;
        res.ovf = ovf_flag;
        case (cmd)
            CMD_POP, CMD_PEEK:
            begin
                if (head != tail)
                begin
                    res.data  = ring[head];
                    res.valid = 1'b1;
                    if (cmd == CMD_POP)
                        head = (head + 1) % FIFO_DEPTH;
                end
            end
            CMD_FLUSH:
            begin
                head = 0;
                tail = 0;
            end
            CMD_CLR_OVF:
                ovf_flag = 1'b0;
            default:
                ;
        endcase
        res.fill = FILL_W'((tail + FIFO_DEPTH - head) % FIFO_DEPTH);
    endtask

    always @(posedge clk)
    begin
        read_result_t want;
        read_result_t got;
        if (!rst_n)
            reset_model();
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CENTER_TICKS: center_cfg = cfg_data;
                    CFG_BIT_TICKS:    bit_cfg    = cfg_data;
                    CFG_STOP_TICKS:   stop_cfg   = cfg_data;
                    default:          ;
                endcase
            end

            // result transfer against the oldest prediction
            if (result_valid && !result_stall)
            begin
                got = {read_data, read_valid, fill_count, overflow};
                if (expected_reads.size() == 0)
                begin
                    $error("result transfer with no read expected");
                    error_count++;
                end
                else
                begin
                    want = expected_reads.pop_front();
                    reads_checked++;
                    if (got.data !== want.data)
                    begin
                        $error("read_data: expected %0h, got %0h", want.data, got.data);
                        error_count++;
                    end
                    if (got.valid !== want.valid)
                    begin
                        $error("read_valid: expected %0b, got %0b", want.valid, got.valid);
                        error_count++;
                    end
                    if (got.fill !== want.fill)
                    begin
                        $error("fill_count: expected %0d, got %0d", want.fill, got.fill);
                        error_count++;
                    end
                    if (got.ovf !== want.ovf)
                    begin
                        $error("overflow: expected %0b, got %0b", want.ovf, got.ovf);
                        error_count++;
                    end
                end
            end

            // tick transfer
            if (item_valid && !item_stall)
            begin
                predict_read(command, rx_level, want);
                expected_reads.push_back(want);
            end
            pending = expected_reads.size();
        end
    end

endmodule

// ===== bench/uart_receiver_with_ring_buffer_tb.sv =====
// ----------------------------------------------------------------------------
// uart_receiver_with_ring_buffer_tb
// Drives sample ticks and host commands into the receiver: a short directed
// run, then well-formed 8n1 frames with random bytes mixed with missing stop
// bits, line noise and glitches, over several timing settings from zero to
// full scale. Both channels idle at random; one long result hold-off backs
// the block up and a no-pop run overflows the buffer. A separate checker
// predicts and compares every read result.
// ----------------------------------------------------------------------------
module uart_receiver_with_ring_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import urrb_pkg::*;

    localparam int FIFO_DEPTH = 64;
    localparam int LIMIT      = 200000;
    localparam int HOLD_LEN   = 80;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    logic [CMD_W-1:0]     command      = CMD_NONE;
    logic                 rx_level     = 1'b1;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [BYTE_W-1:0]    read_data;
    logic                 read_valid;
    logic [FILL_W-1:0]    fill_count;
    logic                 overflow;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_CENTER_TICKS;
    logic [TICK_W-1:0]    cfg_data     = '0;

    int error_count;
    int pending;
    int reads_checked;
    int bytes_stored;
    int bytes_dropped;

    // stimulus shaping
    int                idle_pct  = 0;
    int                stall_pct = 0;
    int                pop_pct   = 0;
    int                flush_pct = 0;
    logic              want_hold = 1'b0;
    int                hold_count = 0;
    int                items_sent = 0;
    int                cycle_count = 0;
    logic [TICK_W-1:0] cur_center = CENTER_TICKS_RST;
    logic [TICK_W-1:0] cur_bit    = BIT_TICKS_RST;
    logic [TICK_W-1:0] cur_stop   = STOP_TICKS_RST;

    uart_receiver_with_ring_buffer #(.FIFO_DEPTH(FIFO_DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .rx_level     (rx_level),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .read_data    (read_data),
        .read_valid   (read_valid),
        .fill_count   (fill_count),
        .overflow     (overflow),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    urrb_read_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_read_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .command       (command),
        .rx_level      (rx_level),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .read_data     (read_data),
        .read_valid    (read_valid),
        .fill_count    (fill_count),
        .overflow      (overflow),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending       (pending),
        .reads_checked (reads_checked),
        .bytes_stored  (bytes_stored),
        .bytes_dropped (bytes_dropped)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: one long hold-off when asked, random stalls otherwise
    always @(negedge clk)
    begin
        if (want_hold && hold_count < HOLD_LEN)
        begin
            result_stall <= 1'b1;
            hold_count++;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    // host command mix for the current phase
    function automatic logic [CMD_W-1:0] next_command();
        int r;
        r = $urandom_range(99);
        if (r < pop_pct)
            return CMD_POP;
        r -= pop_pct;
        if (r < 8)
            return CMD_PEEK;
        r -= 8;
        if (r < flush_pct)
            return CMD_FLUSH;
        r -= flush_pct;
        if (r < 3)
            return CMD_CLR_OVF;
        r -= 3;
        if (r < 2)
            return CMD_W'($urandom_range(2 ** CMD_W - 1, CMD_CLR_OVF + 1));
        return CMD_NONE;
    endfunction

    // one tick transfer, with random idle cycles ahead of it
    task automatic put_tick(input logic [CMD_W-1:0] cmd, input logic lvl);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        command    <= cmd;
        rx_level   <= lvl;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // stop sending and wait for every read result
    task automatic wait_quiet();
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // write all three timing registers back to back
    task automatic set_timing(input logic [TICK_W-1:0] center_v,
                              input logic [TICK_W-1:0] bit_v,
                              input logic [TICK_W-1:0] stop_v);
        logic [TICK_W-1:0]    vals [3];
        logic [CFG_IDX_W-1:0] idxs [3];
        vals = '{center_v, bit_v, stop_v};
        idxs = '{CFG_CENTER_TICKS, CFG_BIT_TICKS, CFG_STOP_TICKS};
        for (int k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[k];
            cfg_data  <= vals[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_valid  <= 1'b0;
        cur_center = center_v;
        cur_bit    = bit_v;
        cur_stop   = stop_v;
    endtask

    // 8n1 frame drawn to land each bit on its sample tick
    task automatic send_frame(input logic [BYTE_W-1:0] value, input logic stop_lvl,
                              input int gap);
        int c;
        int b;
        int s;
        c = cur_center;
        b = (cur_bit == 0) ? 1 : cur_bit;
        s = (cur_stop == 0) ? 1 : cur_stop;
        repeat (c + 1)
            put_tick(next_command(), 1'b0);
        for (int k = 0; k < BYTE_W; k++)
            repeat (b)
                put_tick(next_command(), value[k]);
        repeat (s)
            put_tick(next_command(), stop_lvl);
        repeat (gap)
            put_tick(next_command(), 1'b1);
    endtask

    // mostly clean frames, some missing stop bits, some line noise
    task automatic run_random(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_frame(BYTE_W'($urandom), 1'b1, $urandom_range(3));
            else if (pick < 82)
            begin
                send_frame(BYTE_W'($urandom), 1'b0, 0);
                repeat ($urandom_range(3))
                    put_tick(next_command(), 1'b0);
            end
            else
                repeat ($urandom_range(8, 1))
                    put_tick(next_command(), 1'($urandom));
        end
    endtask

    initial
    begin
        repeat (12)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // host commands on an empty buffer at reset timing
        put_tick(CMD_NONE, 1'b1);
        put_tick(CMD_POP, 1'b1);
        put_tick(CMD_PEEK, 1'b1);
        put_tick(CMD_FLUSH, 1'b1);
        put_tick(CMD_CLR_OVF, 1'b1);

        // zero delays: no centering wait, bit and stop of zero act as one
        wait_quiet();
        set_timing('0, '0, '0);
        send_frame(8'hA5, 1'b1, 0);
        put_tick(CMD_PEEK, 1'b1);
        put_tick(CMD_POP, 1'b1);
        put_tick(CMD_POP, 1'b1);
        // missing stop bit: byte kept, low line must not start a frame
        send_frame(8'h5A, 1'b0, 0);
        put_tick(CMD_NONE, 1'b0);

        // no idling
        pop_pct   = 25;
        flush_pct = 1;
        wait_quiet();
        set_timing(16'd2, 16'd3, 16'd2);
        run_random(180);

        // sender mostly idle
        wait_quiet();
        set_timing(16'd1, 16'd1, 16'd1);
        idle_pct = 75;
        run_random(180);

        // receiver mostly stalled
        wait_quiet();
        set_timing(16'd3, 16'd2, 16'd4);
        idle_pct  = 0;
        stall_pct = 75;
        run_random(180);

        // light idling on both sides, random small timing
        wait_quiet();
        set_timing(TICK_W'($urandom_range(4)), TICK_W'($urandom_range(4, 1)),
                   TICK_W'($urandom_range(4, 1)));
        idle_pct  = 9;
        stall_pct = 9;
        run_random(180);

        // no pops: buffer fills and overflows, long result hold-off on top
        wait_quiet();
        set_timing(16'd0, 16'd1, 16'd1);
        idle_pct  = 0;
        stall_pct = 0;
        pop_pct   = 0;
        flush_pct = 0;
        want_hold = 1'b1;
        repeat (FIFO_DEPTH + 6)
            send_frame(BYTE_W'($urandom), 1'b1, 0);
        wait_quiet();

        // drain the buffer again
        pop_pct   = 45;
        flush_pct = 1;
        idle_pct  = 9;
        stall_pct = 9;
        run_random(150);

        // full-scale timing, then shortened while a frame is in its centering wait
        wait_quiet();
        idle_pct  = 0;
        stall_pct = 0;
        set_timing('1, '1, '1);
        put_tick(next_command(), 1'b1);
        repeat (30)
            put_tick(next_command(), 1'b0);
        wait_quiet();
        set_timing(16'd2, 16'd2, 16'd2);
        run_random(80);

        // wrap up
        wait_quiet();
        repeat (8)
            @(negedge clk);
        $display("%0d line ticks over timing from zero to full scale, with idling and back-pressure",
                 items_sent);
        $display("%0d reads checked, %0d bytes received, %0d dropped on a full buffer",
                 reads_checked, bytes_stored, bytes_dropped);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
